@@ rtl/bpdc_pkg.sv @@
`default_nettype none

package bpdc_pkg;

	localparam int unsigned LevelsW = 3;
	localparam int unsigned MaskW = 3;
	localparam int unsigned CountW = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned NumButtonsDefault = 3;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [CountW-1:0] ClickMinReset = 16'd5;
	localparam logic [CountW-1:0] LongMinReset = 16'd20;
	localparam logic [CountW-1:0] TimeoutReset = 16'd50;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CLICK_MIN = 2'd0,
		REG_LONG_MIN  = 2'd1,
		REG_TIMEOUT   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CountW-1:0] click_min;
		logic [CountW-1:0] long_min;
		logic [CountW-1:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic click;
		logic long_press;
	} event_t;

endpackage

`default_nettype wire

@@ rtl/bpdc_cfg.sv @@
`default_nettype none

module bpdc_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [bpdc_pkg::CfgIdxW-1:0] wr_index,
	input  wire logic [bpdc_pkg::CountW-1:0]  wr_data,
	output bpdc_pkg::cfg_t                    cfg
);

	bpdc_pkg::cfg_t cfg_q;

	// Writes to an index with no register behind it fall through the case.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_min <= bpdc_pkg::ClickMinReset;
			cfg_q.long_min <= bpdc_pkg::LongMinReset;
			cfg_q.timeout_limit <= bpdc_pkg::TimeoutReset;
		end else if (wr_en) begin
			case (wr_index)
				bpdc_pkg::REG_CLICK_MIN: cfg_q.click_min <= wr_data;
				bpdc_pkg::REG_LONG_MIN: cfg_q.long_min <= wr_data;
				bpdc_pkg::REG_TIMEOUT: cfg_q.timeout_limit <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/bpdc_button.sv @@
`default_nettype none

module bpdc_button (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     pressed,
	input  wire bpdc_pkg::cfg_t cfg,
	output bpdc_pkg::event_t evt
);

	logic [bpdc_pkg::CountW-1:0] count_q;
	logic in_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			if (!pressed) begin
				count_q <= '0;
			end else if (count_q != bpdc_pkg::CountMax) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// A zero count means no press happened, so it never yields an event.
	assign in_window = !pressed && (count_q != '0) && (count_q >= cfg.click_min)
		&& (count_q < cfg.timeout_limit);

	assign evt.click = in_window && (count_q < cfg.long_min);
	assign evt.long_press = in_window && (count_q >= cfg.long_min);

endmodule

`default_nettype wire

@@ rtl/button_press_duration_classifier.sv @@
`default_nettype none

// Classifies button releases by how long each button was held. Each accepted beat
// carries one scan tick of active-low button levels; every button keeps a saturating
// hold counter, and on release the count is compared against click_min, long_min and
// timeout_limit to set that button's bit in click_mask or long_mask. One beat is
// accepted every cycle while item_stall is low, and one result beat leaves for each:
// an input register feeds the per-button counter and compare logic, whose result
// lands in the output register. Buttons numbered three and up see no level bit and
// always read released. Configuration is written through the cfg port, which is
// always ready.
module button_press_duration_classifier #(
	parameter int unsigned NUM_BUTTONS = bpdc_pkg::NumButtonsDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [bpdc_pkg::LevelsW-1:0]  levels,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [bpdc_pkg::MaskW-1:0]         click_mask,
	output logic [bpdc_pkg::MaskW-1:0]         long_mask,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bpdc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [bpdc_pkg::CountW-1:0]   cfg_data
);

	logic valid_s1;
	logic [bpdc_pkg::LevelsW-1:0] levels_s1;
	logic valid_s2;
	logic [bpdc_pkg::MaskW-1:0] click_s2;
	logic [bpdc_pkg::MaskW-1:0] long_s2;
	logic adv;
	logic item_acc;
	bpdc_pkg::cfg_t cfg;
	bpdc_pkg::event_t evt [NUM_BUTTONS];
	logic [bpdc_pkg::MaskW-1:0] click_d;
	logic [bpdc_pkg::MaskW-1:0] long_d;

	assign cfg_ready = 1'b1;

	bpdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// The output register frees up when empty or when its beat is taken.
	assign adv = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign item_acc = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			levels_s1 <= levels;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		logic pressed;
		if (i < bpdc_pkg::LevelsW) begin : g_pin
			assign pressed = !levels_s1[i];
		end else begin : g_nopin
			assign pressed = 1'b0;
		end

		bpdc_button u_button (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (valid_s1 && adv),
			.pressed(pressed),
			.cfg    (cfg),
			.evt    (evt[i])
		);
	end

	for (genvar j = 0; j < bpdc_pkg::MaskW; j++) begin : g_mask
		if (j < NUM_BUTTONS) begin : g_used
			assign click_d[j] = evt[j].click;
			assign long_d[j] = evt[j].long_press;
		end else begin : g_unused
			assign click_d[j] = 1'b0;
			assign long_d[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			click_s2 <= click_d;
			long_s2 <= long_d;
		end
	end

	assign result_valid = valid_s2;
	assign click_mask = click_s2;
	assign long_mask = long_s2;

	// A release is either a click or a long press, never both.
	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((click_mask & long_mask) == '0))
		else $error("click and long press flagged on the same button");

	// Every beat that leaves the input register shows up as a result beat.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> result_valid)
		else $error("processed beat did not reach the output register");

	// With every button held, nothing is released, so no event can appear.
	a_held_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && (levels_s1 == '0)) |=> (click_mask == '0 && long_mask == '0))
		else $error("event reported while all buttons were held");

endmodule

`default_nettype wire

@@ sim/bpdc_release_monitor.sv @@
`default_nettype none

// Watches all three channels of the classifier, keeps its own copy of the thresholds and
// hold counters, and compares every result beat against the oldest predicted masks.
module bpdc_release_monitor
	import bpdc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire logic                item_stall,
	input  wire logic [LevelsW-1:0]  levels,
	input  wire logic                result_valid,
	input  wire logic                result_stall,
	input  wire logic [MaskW-1:0]    click_mask,
	input  wire logic [MaskW-1:0]    long_mask,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CountW-1:0]   cfg_data,
	output int                       mismatches,
	output int                       pending_masks,
	output int                       clicks_seen,
	output int                       longs_seen
);

	typedef struct packed {
		logic [MaskW-1:0] click;
		logic [MaskW-1:0] longp;
	} masks_t;

	masks_t            predicted_masks[$];
	cfg_t              thresholds;
	logic [CountW-1:0] held_ticks[NumButtonsDefault];

	// Advances the hold counters by one scan tick and returns the masks of the releases.
	function automatic masks_t classify_tick(input logic [LevelsW-1:0] lv);
		masks_t r;
		logic [CountW-1:0] c;
		r = '0;
		for (int b = 0; b < NumButtonsDefault; b++) begin
			c = held_ticks[b];
			if (!lv[b]) begin
				if (c != CountMax)
					held_ticks[b] = c + 1'b1;
			end else begin
				if (c != '0 && c >= thresholds.click_min && c < thresholds.timeout_limit) begin
					if (c < thresholds.long_min)
						r.click[b] = 1'b1;
					else
						r.longp[b] = 1'b1;
				end
				held_ticks[b] = '0;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		masks_t want;
		if (!arst_n) begin
			thresholds = '{ClickMinReset, LongMinReset, TimeoutReset};
			for (int b = 0; b < NumButtonsDefault; b++)
				held_ticks[b] = '0;
			predicted_masks.delete();
			pending_masks = 0;
			mismatches = 0;
			clicks_seen = 0;
			longs_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLICK_MIN: thresholds.click_min = cfg_data;
					REG_LONG_MIN:  thresholds.long_min = cfg_data;
					REG_TIMEOUT:   thresholds.timeout_limit = cfg_data;
					default: ;
				endcase
			end
			// Compare before pushing, so a beat never pairs with a tick taken in the same cycle.
			if (result_valid && !result_stall) begin
				if (predicted_masks.size() == 0) begin
					$error("result beat with nothing predicted: click_mask=%0h long_mask=%0h",
						click_mask, long_mask);
					mismatches++;
				end else begin
					want = predicted_masks.pop_front();
					if (click_mask !== want.click) begin
						$error("click_mask: expected %0h, actual %0h", want.click, click_mask);
						mismatches++;
					end
					if (long_mask !== want.longp) begin
						$error("long_mask: expected %0h, actual %0h", want.longp, long_mask);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				want = classify_tick(levels);
				clicks_seen += $countones(want.click);
				longs_seen += $countones(want.longp);
				predicted_masks.push_back(want);
			end
			pending_masks = predicted_masks.size();
		end
	end

endmodule

`default_nettype wire

@@ sim/button_press_duration_classifier_tb.sv @@
`default_nettype none

module button_press_duration_classifier_tb;
	import bpdc_pkg::*;

	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
	localparam int StallLimit = 2000;
	localparam int TicksPerSetting = 85;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [LevelsW-1:0]  levels = '1;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [MaskW-1:0]    click_mask;
	logic [MaskW-1:0]    long_mask;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CountW-1:0]   cfg_data = '0;

	int mismatches;
	int pending_masks;
	int clicks_seen;
	int longs_seen;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int ticks_sent = 0;
	int settings_run = 0;
	int idle_cycles = 0;

	// Thresholds currently programmed, used to aim hold lengths at the boundaries.
	int cur_click = ClickMinReset;
	int cur_long = LongMinReset;
	int cur_timeout = TimeoutReset;
	int hold_left[NumButtonsDefault];
	int gap_left[NumButtonsDefault];

	button_press_duration_classifier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.levels(levels),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.click_mask(click_mask),
		.long_mask(long_mask),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bpdc_release_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.levels(levels),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.click_mask(click_mask),
		.long_mask(long_mask),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending_masks(pending_masks),
		.clicks_seen(clicks_seen),
		.longs_seen(longs_seen)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("button_press_duration_classifier_tb NOT OK");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_tick(input logic [LevelsW-1:0] lv);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		levels <= lv;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_masks != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_thresholds(input int cm, input int lm, input int to);
		drain();
		write_reg(REG_CLICK_MIN, cm[CountW-1:0]);
		write_reg(REG_LONG_MIN, lm[CountW-1:0]);
		write_reg(REG_TIMEOUT, to[CountW-1:0]);
		// An unmapped index must leave all thresholds alone.
		write_reg(RegUnused, CountW'($urandom));
		cfg_valid <= 1'b0;
		cur_click = cm;
		cur_long = lm;
		cur_timeout = to;
		settings_run++;
	endtask

	// Presses each button for its own number of ticks, then releases all of them.
	task automatic hold_run(input int d0, input int d1, input int d2);
		int longest;
		logic [LevelsW-1:0] lv;
		longest = d0;
		if (d1 > longest) longest = d1;
		if (d2 > longest) longest = d2;
		for (int t = 0; t < longest; t++) begin
			lv = {t >= d2, t >= d1, t >= d0};
			send_tick(lv);
		end
		send_tick('1);
	endtask

	function automatic int pick_hold();
		int span;
		int n;
		span = (cur_timeout > 8) ? cur_timeout : 8;
		case ($urandom_range(0, 8))
			0: n = cur_click - 1;
			1: n = cur_click;
			2: n = cur_long - 1;
			3: n = cur_long;
			4: n = cur_timeout - 1;
			5: n = cur_timeout;
			6: n = cur_timeout + 1;
			default: n = $urandom_range(1, span);
		endcase
		if (n < 0)
			n = 0;
		if (n > 64)
			n = $urandom_range(1, 64);
		return n;
	endfunction

	// Mostly whole presses of boundary lengths per button, with some raw noise mixed in.
	task automatic run_random(input int n);
		int pause_at;
		logic [LevelsW-1:0] lv;
		pause_at = $urandom_range(10, n - 10);
		for (int b = 0; b < NumButtonsDefault; b++) begin
			hold_left[b] = 0;
			gap_left[b] = 1;
		end
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			if ($urandom_range(0, 9) == 0) begin
				lv = LevelsW'($urandom);
			end else begin
				for (int b = 0; b < NumButtonsDefault; b++) begin
					if (hold_left[b] == 0 && gap_left[b] == 0) begin
						hold_left[b] = pick_hold();
						gap_left[b] = $urandom_range(1, 3);
					end
					if (hold_left[b] > 0) begin
						lv[b] = 1'b0;
						hold_left[b]--;
					end else begin
						lv[b] = 1'b1;
						gap_left[b]--;
					end
				end
			end
			send_tick(lv);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset thresholds: bounce just under click_min, a click and a long press.
		hold_run(4, 5, 20);
		program_thresholds(2, 4, 6);
		hold_run(1, 2, 3);
		// A count equal to the timeout gives no event.
		hold_run(4, 5, 6);

		snd_idle_pct = 6;
		rcv_idle_pct = 81;
		program_thresholds(5, 20, 50);
		run_random(TicksPerSetting);
		program_thresholds(1, 3, 8);
		run_random(TicksPerSetting);
		// Zero click_min acts as one.
		program_thresholds(0, 2, 5);
		run_random(TicksPerSetting);

		snd_idle_pct = 81;
		rcv_idle_pct = 6;
		// long_min at or below click_min leaves no clicks.
		program_thresholds(6, 3, 9);
		run_random(TicksPerSetting);
		// long_min at or above the timeout leaves no long presses.
		program_thresholds(2, 10, 6);
		run_random(TicksPerSetting);
		program_thresholds(0, 0, 0);
		run_random(TicksPerSetting);
		program_thresholds(65535, 65535, 65535);
		run_random(TicksPerSetting);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		program_thresholds(1, 0, 7);
		run_random(TicksPerSetting);
		program_thresholds(1, 65535, 65535);
		run_random(TicksPerSetting);

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d scan ticks over %0d threshold settings with varied stalls.",
			ticks_sent, settings_run);
		$display("Predicted %0d click and %0d long press releases; %0d mismatches.",
			clicks_seen, longs_seen, mismatches);
		if (mismatches == 0)
			$display("button_press_duration_classifier_tb OK");
		else
			$display("button_press_duration_classifier_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/bpdc_pkg.sv
rtl/bpdc_cfg.sv
rtl/bpdc_button.sv
rtl/button_press_duration_classifier.sv
sim/bpdc_release_monitor.sv
sim/button_press_duration_classifier_tb.sv
